>>> rtl/core/assert_macros.svh
// assert_macros.svh: shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/imbe_pkg.sv
// ----------------------------------------------------------------------------
// imbe_pkg
// Types and constants of the tick-level I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package imbe_pkg;

    // Command codes
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_START     = 3'd1,
        OP_STOP      = 3'd2,
        OP_WRITE     = 3'd3,
        OP_READ      = 3'd4,
        OP_DISP_CMD  = 3'd5,
        OP_DISP_DATA = 3'd6
    } t_op;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_ACK_TIMEOUT    = 1'b0,
        REG_DEVICE_ADDRESS = 1'b1
    } t_reg_idx;

    localparam int unsigned CFG_W = 8;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [7:0] DEV_ADDR_RST    = 8'h78;
    localparam logic [7:0] CTRL_CMD        = 8'h00;
    localparam logic [7:0] CTRL_DATA       = 8'h40;

    // Bus phases, one-hot
    typedef enum logic [18:0] {
        PH_IDLE     = 19'h00001,
        PH_START1   = 19'h00002,
        PH_START2   = 19'h00004,
        PH_STOP1    = 19'h00008,
        PH_STOP2    = 19'h00010,
        PH_STOP3    = 19'h00020,
        PH_TO1      = 19'h00040,
        PH_TO2      = 19'h00080,
        PH_TO3      = 19'h00100,
        PH_TX_A     = 19'h00200,
        PH_TX_B     = 19'h00400,
        PH_TX_C     = 19'h00800,
        PH_TX_END   = 19'h01000,
        PH_ACK_REL  = 19'h02000,
        PH_ACK_POLL = 19'h04000,
        PH_RX_LOW   = 19'h08000,
        PH_RX_HIGH  = 19'h10000,
        PH_MA_LOW   = 19'h20000,
        PH_MA_HIGH  = 19'h40000
    } t_phase;

    // One tick request
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } t_req;

    // One tick result
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_ack;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/core/imbe_if.sv
// ----------------------------------------------------------------------------
// imbe_if
// Valid/ready channels for tick requests and tick results.
// ----------------------------------------------------------------------------
`default_nettype none

interface imbe_req_if;
    logic             valid;
    logic             ready;
    imbe_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imbe_res_if;
    logic             valid;
    logic             ready;
    imbe_pkg::t_res   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Tick-level I2C master: one request is one bus delay period.
// ----------------------------------------------------------------------------
// Each request on i_req is one bus tick. While idle, the op field starts an
// operation (start, stop, write byte with acknowledge wait, read byte with
// master ACK/NACK, or a three-byte display write of address, control byte and
// payload); the request that carries the command is also the operation's first
// tick, and op is ignored while busy. Every request yields exactly one result
// with the pin levels for that tick, busy/done, the last read byte and the
// missing-acknowledge flag. The engine takes one request per clock: the whole
// tick is computed in one pass of logic from the phase registers into a single
// result register, so the result shows in the cycle after acceptance and a new
// request is accepted in the same cycle as long as the result register is
// empty or being drained. A stalled result holds the input side. There is no
// clearing pass after reset. Write ack_timeout and device_address through the
// config port only while no operation is running.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    imbe_req_if.sink               i_req,
    imbe_res_if.source             o_res,
    input  wire                    i_cfg_we,
    input  imbe_pkg::t_reg_idx     i_cfg_idx,
    input  wire [7:0]              i_cfg_wdata
);
    import imbe_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] r_ack_timeout;
    logic [CFG_W-1:0] r_device_address;

    // Engine state
    t_phase      r_phase,   n_phase;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift,   n_shift;
    logic [7:0]  r_wait,    n_wait;
    logic [1:0]  r_tbyte,   n_tbyte;
    logic        r_scl,     n_scl;
    logic        r_sda,     n_sda;
    logic        r_drv,     n_drv;
    logic        r_no_ack,  n_no_ack;
    logic        r_sack,    n_sack;
    logic [8:0]  r_payload, n_payload;
    logic [2:0]  r_cur_op,  n_cur_op;
    logic [7:0]  r_read,    n_read;

    // Result register
    t_res        r_res, n_res;
    logic        r_res_valid;

    logic        accept;
    logic        done;
    logic        drop_scl;
    logic        do_adv;
    logic        disp;

    // Take a request whenever the result slot is free or draining
    assign i_req.ready = i_rst_n && (!r_res_valid || o_res.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    // Display writes run all three bytes; plain writes end after one
    assign disp = (r_cur_op == OP_DISP_CMD) || (r_cur_op == OP_DISP_DATA);

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_wait    = r_wait;
        n_tbyte   = r_tbyte;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_drv     = r_drv;
        n_no_ack  = r_no_ack;
        n_sack    = r_sack;
        n_payload = r_payload;
        n_cur_op  = r_cur_op;
        n_read    = r_read;
        done      = 1'b0;
        drop_scl  = 1'b0;
        do_adv    = 1'b0;

        // Command decode: only while idle, same tick runs the first phase
        if (r_phase == PH_IDLE) begin
            case (i_req.data.op)
                OP_START: begin
                    n_cur_op = i_req.data.op;
                    n_phase  = PH_START1;
                end
                OP_STOP: begin
                    n_cur_op = i_req.data.op;
                    n_phase  = PH_STOP1;
                end
                OP_WRITE: begin
                    n_cur_op  = i_req.data.op;
                    n_no_ack  = 1'b0;
                    n_shift   = i_req.data.data_byte;
                    n_bit_cnt = 4'd0;
                    n_phase   = PH_TX_A;
                end
                OP_READ: begin
                    n_cur_op  = i_req.data.op;
                    n_sack    = i_req.data.send_ack;
                    n_shift   = 8'd0;
                    n_bit_cnt = 4'd0;
                    n_phase   = PH_RX_LOW;
                end
                OP_DISP_CMD, OP_DISP_DATA: begin
                    n_cur_op  = i_req.data.op;
                    n_no_ack  = 1'b0;
                    n_payload = {(i_req.data.op == OP_DISP_DATA), i_req.data.data_byte};
                    n_tbyte   = 2'd0;
                    n_phase   = PH_START1;
                end
                default: begin
                end
            endcase
        end

        n_res.busy_res = (n_phase != PH_IDLE);

        case (n_phase)
            PH_IDLE: begin
            end
            PH_START1: begin
                {n_scl, n_sda, n_drv} = 3'b111;
                n_phase = PH_START2;
            end
            PH_START2: begin
                {n_scl, n_sda, n_drv} = 3'b101;
                drop_scl = 1'b1;
                if ((n_cur_op == OP_DISP_CMD) || (n_cur_op == OP_DISP_DATA)) begin
                    n_tbyte   = 2'd0;
                    n_shift   = r_device_address;
                    n_bit_cnt = 4'd0;
                    n_phase   = PH_TX_A;
                end else begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
            end
            PH_STOP1, PH_TO1: begin
                {n_scl, n_sda, n_drv} = 3'b001;
                n_phase = (n_phase == PH_TO1) ? PH_TO2 : PH_STOP2;
            end
            PH_STOP2, PH_TO2: begin
                {n_scl, n_sda, n_drv} = 3'b101;
                n_phase = (n_phase == PH_TO2) ? PH_TO3 : PH_STOP3;
            end
            PH_STOP3: begin
                {n_scl, n_sda, n_drv} = 3'b111;
                n_phase = PH_IDLE;
                done    = 1'b1;
            end
            PH_TO3: begin
                {n_scl, n_sda, n_drv} = 3'b111;
                do_adv = 1'b1;
            end
            PH_TX_A: begin
                // hold the previous data level while SCL is low
                {n_scl, n_drv} = 2'b01;
                n_phase = PH_TX_B;
            end
            PH_TX_B: begin
                {n_scl, n_sda, n_drv} = {1'b0, n_shift[7], 1'b1};
                n_phase = PH_TX_C;
            end
            PH_TX_C: begin
                {n_scl, n_drv} = 2'b11;
                n_shift   = {n_shift[6:0], 1'b0};
                n_bit_cnt = n_bit_cnt + 4'd1;
                n_phase   = (n_bit_cnt >= 4'd8) ? PH_TX_END : PH_TX_A;
            end
            PH_TX_END: begin
                {n_scl, n_drv} = 2'b01;
                n_phase = PH_ACK_REL;
            end
            PH_ACK_REL: begin
                {n_scl, n_sda, n_drv} = 3'b010;
                n_wait  = 8'd0;
                n_phase = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
                {n_scl, n_sda, n_drv} = 3'b110;
                if (!i_req.data.sda_in) begin
                    drop_scl = 1'b1;
                    do_adv   = 1'b1;
                end else if (n_wait >= r_ack_timeout) begin
                    n_no_ack = 1'b1;
                    n_phase  = PH_TO1;
                end else begin
                    n_wait = n_wait + 8'd1;
                end
            end
            PH_RX_LOW: begin
                {n_scl, n_drv} = 2'b00;
                n_phase = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
                {n_scl, n_drv} = 2'b10;
                n_shift   = {n_shift[6:0], i_req.data.sda_in};
                n_bit_cnt = n_bit_cnt + 4'd1;
                if (n_bit_cnt >= 4'd8) begin
                    n_read  = n_shift;
                    n_phase = PH_MA_LOW;
                end else begin
                    n_phase = PH_RX_LOW;
                end
            end
            PH_MA_LOW: begin
                {n_scl, n_sda, n_drv} = {1'b0, !n_sack, 1'b1};
                n_phase = PH_MA_HIGH;
            end
            PH_MA_HIGH: begin
                {n_scl, n_drv} = 2'b11;
                drop_scl = 1'b1;
                n_phase  = PH_IDLE;
                done     = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // Advance to the next byte of a display write, its stop, or finish
        if (do_adv) begin
            if (disp && (r_tbyte < 2'd2)) begin
                n_tbyte   = r_tbyte + 2'd1;
                n_shift   = (r_tbyte == 2'd0)
                          ? (r_payload[8] ? CTRL_DATA : CTRL_CMD)
                          : r_payload[7:0];
                n_bit_cnt = 4'd0;
                n_phase   = PH_TX_A;
            end else if (disp) begin
                n_phase = PH_STOP1;
            end else begin
                n_phase = PH_IDLE;
                done    = 1'b1;
            end
        end

        n_res.scl_level = n_scl;
        n_res.sda_level = n_sda;
        n_res.sda_drive = n_drv;
        n_res.done_res  = done;
        n_res.read_data = n_read;
        n_res.no_ack    = n_no_ack;

        // Leave SCL low after this tick
        if (drop_scl) begin
            n_scl = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout    <= ACK_TIMEOUT_RST;
            r_device_address <= DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACK_TIMEOUT:    r_ack_timeout    <= i_cfg_wdata;
                REG_DEVICE_ADDRESS: r_device_address <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Engine state advances once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= 4'd0;
            r_shift   <= 8'd0;
            r_wait    <= 8'd0;
            r_tbyte   <= 2'd0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_drv     <= 1'b1;
            r_no_ack  <= 1'b0;
            r_sack    <= 1'b0;
            r_payload <= 9'd0;
            r_cur_op  <= OP_NONE;
            r_read    <= 8'd0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_wait    <= n_wait;
            r_tbyte   <= n_tbyte;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_drv     <= n_drv;
            r_no_ack  <= n_no_ack;
            r_sack    <= n_sack;
            r_payload <= n_payload;
            r_cur_op  <= n_cur_op;
            r_read    <= n_read;
        end
    end

    // Result register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/imbe_checker.sv
// ----------------------------------------------------------------------------
// imbe_checker
// Port-level assertions for the I2C master byte engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module imbe_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_req_valid,
    input  wire                i_req_ready,
    input  wire                i_res_valid,
    input  wire                i_res_ready,
    input  imbe_pkg::t_res     i_res_data
);
    import imbe_pkg::*;

    // A stalled result keeps its value
    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_data), "stalled result changed")

    // Every accepted request shows a result next cycle
    `ASSERT_NEXT(a_req_to_res, i_clk, i_rst_n, i_req_valid && i_req_ready, i_res_valid, "accepted request produced no result")

    // No request taken while the result slot is full and stalled
    `ASSERT_IMPLY(a_no_overrun, i_clk, i_rst_n, i_res_valid && !i_res_ready, !i_req_ready, "request taken over a stalled result")

    // The completion tick belongs to a running operation
    `ASSERT_IMPLY(a_done_busy, i_clk, i_rst_n, i_res_valid && i_res_data.done_res, i_res_data.busy_res, "done without busy")

endmodule

bind i2c_master_byte_engine imbe_checker u_imbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

`default_nettype wire
